// File: rtl/srxd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite run XOR decoder package
// Shared constants, register index codes and store access types.
// ----------------------------------------------------------------------------
package srxd_pkg;

    // Byte store geometry: two byte banks, even and odd addresses.
    localparam int STORE_BYTES = 8192;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int ROWS        = STORE_BYTES / 2;
    localparam int ROW_W       = $clog2(ROWS);

    // Stream codes and register reset values.
    localparam logic [15:0] TERM_WORD     = 16'hFFFF;
    localparam logic [7:0]  ROW_WIDTH_RST = 8'd56;
    localparam logic [7:0]  BOX_MIN_RST   = 8'hFF;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE_APPLY = 2'd0,
        CFG_ORIGIN_X   = 2'd1,
        CFG_ORIGIN_Y   = 2'd2,
        CFG_ROW_WIDTH  = 2'd3
    } t_cfg_idx;

    // Read request to both banks.
    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] addr_even;
        logic [ROW_W-1:0] addr_odd;
    } t_store_rd;

    // Write request to both banks.
    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] addr_even;
        logic [ROW_W-1:0] addr_odd;
        logic [7:0]       data_even;
        logic [7:0]       data_odd;
    } t_store_wr;

    // Registered read data from both banks.
    typedef struct packed {
        logic [7:0] even;
        logic [7:0] odd;
    } t_store_q;

endpackage

// File: rtl/srxd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite run XOR decoder channels
// Input word channel and result channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface srxd_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

interface srxd_out_if;
    logic        valid;
    logic        ready;
    logic        write_valid;
    logic [12:0] store_index;
    logic [7:0]  new_low_byte;
    logic [7:0]  new_high_byte;
    logic        out_of_range;
    logic        cell_done;
    logic [7:0]  box_left;
    logic [7:0]  box_top;
    logic [7:0]  box_width;
    logic [7:0]  box_height;

    modport source (
        output valid, input ready,
        output write_valid, output store_index, output new_low_byte,
        output new_high_byte, output out_of_range, output cell_done,
        output box_left, output box_top, output box_width, output box_height
    );
    modport sink (
        input valid, output ready,
        input write_valid, input store_index, input new_low_byte,
        input new_high_byte, input out_of_range, input cell_done,
        input box_left, input box_top, input box_width, input box_height
    );
endinterface

// File: rtl/srxd_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite run XOR decoder byte store
// Two byte banks (even and odd addresses) with registered reads and a
// clearing sweep after reset that zeroes one row per cycle.
// ----------------------------------------------------------------------------
module srxd_store import srxd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_store_rd i_rd,
    input  t_store_wr i_wr,
    output t_store_q  o_q,
    output logic      o_busy
);

    logic [7:0]       r_mem_even [ROWS];
    logic [7:0]       r_mem_odd  [ROWS];
    logic             r_clr_busy;
    logic [ROW_W-1:0] r_clr_idx;
    t_store_q         r_q;

    // Clearing sweep: runs from reset until the last row is zeroed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == ROW_W'(ROWS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Write port: the sweep has priority while it runs.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem_even[r_clr_idx] <= 8'h00;
            r_mem_odd[r_clr_idx]  <= 8'h00;
        end else if (i_wr.en) begin
            r_mem_even[i_wr.addr_even] <= i_wr.data_even;
            r_mem_odd[i_wr.addr_odd]   <= i_wr.data_odd;
        end
    end

    // Read port: data is held while no new read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_q.even <= r_mem_even[i_rd.addr_even];
            r_q.odd  <= r_mem_odd[i_rd.addr_odd];
        end
    end

    assign o_q    = r_q;
    assign o_busy = r_clr_busy;

endmodule

// File: rtl/sprite_run_xor_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite run XOR decoder
// Decodes a sprite cell word stream, tracks the bounding box and XORs run
// data into a byte store.
// ----------------------------------------------------------------------------
// Path: an accepted item is registered in the read stage and then in the
// output register, where its result stays offered until it is taken.
// Throughput: one item per cycle when not stalled; the store read is at
// accept, the XOR write-back one stage later, each pair in its even/odd row.
// Reset: synchronous; afterwards a clearing sweep zeroes the store, one row
// of two bytes per cycle, and no item is accepted meanwhile.
module sprite_run_xor_decoder_unit import srxd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    srxd_in_if.sink              i_in,
    srxd_out_if.source           o_out
);

    // Configuration registers.
    logic       r_mode_apply;
    logic [7:0] r_origin_x;
    logic [7:0] r_origin_y;
    logic [7:0] r_row_width;

    // Stream state.
    logic        r_expect_header, n_expect_header;
    logic [4:0]  r_words_left,    n_words_left;
    logic [15:0] r_write_pointer, n_write_pointer;
    logic [7:0]  r_min_x,     n_min_x;
    logic [7:0]  r_min_y,     n_min_y;
    logic [7:0]  r_max_x_end, n_max_x_end;
    logic [7:0]  r_max_y,     n_max_y;

    // Read stage.
    logic             r_s1_valid;
    logic             r_s1_wr;
    logic             r_s1_oor;
    logic             r_s1_done;
    logic             r_s1_odd;
    logic [12:0]      r_s1_idx;
    logic [7:0]       r_s1_lo;
    logic [7:0]       r_s1_hi;
    logic [ROW_W-1:0] r_s1_addr_even;
    logic [ROW_W-1:0] r_s1_addr_odd;
    logic [7:0]       r_s1_box_left;
    logic [7:0]       r_s1_box_top;
    logic [7:0]       r_s1_box_width;
    logic [7:0]       r_s1_box_height;

    // Output register.
    logic        r_out_valid;
    logic        r_out_wr;
    logic [12:0] r_out_idx;
    logic [7:0]  r_out_lo;
    logic [7:0]  r_out_hi;
    logic        r_out_oor;
    logic        r_out_done;
    logic [7:0]  r_out_box_left;
    logic [7:0]  r_out_box_top;
    logic [7:0]  r_out_box_width;
    logic [7:0]  r_out_box_height;

    // Store access.
    t_store_rd w_rd;
    t_store_wr w_wr;
    t_store_q  w_q;
    logic      w_clr_busy;

    // Handshake and decode signals.
    logic             w_out_free;
    logic             w_s1_free;
    logic             w_accept;
    logic [15:0]      w_word;
    logic             w_is_term;
    logic             w_is_head;
    logic             w_is_data;
    logic [7:0]       w_x;
    logic [7:0]       w_y;
    logic [3:0]       w_runs;
    logic [7:0]       w_xend;
    logic [15:0]      w_dy;
    logic [15:0]      w_dx;
    logic [15:0]      w_prod;
    logic [15:0]      w_head_ptr;
    logic             w_oor;
    logic             w_do_wr;
    logic             w_flag_oor;
    logic [ROW_W-1:0] w_row;
    logic [ROW_W-1:0] w_addr_even;
    logic [7:0]       w_box_width;
    logic [7:0]       w_box_height;
    logic [7:0]       w_cur_lo;
    logic [7:0]       w_cur_hi;
    logic [7:0]       w_new_lo;
    logic [7:0]       w_new_hi;

    srxd_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (w_rd),
        .i_wr    (w_wr),
        .o_q     (w_q),
        .o_busy  (w_clr_busy)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_apply <= 1'b0;
            r_origin_x   <= 8'h00;
            r_origin_y   <= 8'h00;
            r_row_width  <= ROW_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE_APPLY: r_mode_apply <= i_cfg_data[0];
                CFG_ORIGIN_X:   r_origin_x   <= i_cfg_data;
                CFG_ORIGIN_Y:   r_origin_y   <= i_cfg_data;
                CFG_ROW_WIDTH:  r_row_width  <= i_cfg_data;
            endcase
        end
    end

    // Handshake: the read stage moves on when the output register frees up.
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_s1_free  = !r_s1_valid || w_out_free;
    assign i_in.ready = w_s1_free && !w_clr_busy;
    assign w_accept   = i_in.valid && i_in.ready;

    // Word classification and header fields.
    assign w_word    = i_in.word;
    assign w_is_term = r_expect_header && (w_word == TERM_WORD);
    assign w_is_head = r_expect_header && (w_word != TERM_WORD);
    assign w_is_data = !r_expect_header;
    assign w_x       = {2'b00, w_word[3:0], 2'b00};
    assign w_y       = {1'b0, w_word[10:4]};
    assign w_runs    = {1'b0, w_word[14:12]} + 4'd1;
    assign w_xend    = w_x + {2'b00, w_runs, 2'b00};

    // Start address of a run, modulo 2^16.
    assign w_dy       = {8'h00, w_y} - {8'h00, r_origin_y};
    assign w_dx       = {8'h00, w_x} - {8'h00, r_origin_x};
    assign w_prod     = 16'(w_dy * {8'h00, r_row_width});
    assign w_head_ptr = w_prod + w_dx;

    // Data word: range test and bank rows for the byte pair.
    assign w_oor       = ({1'b0, r_write_pointer} + 17'd1) >= 17'(STORE_BYTES);
    assign w_do_wr     = w_is_data && r_mode_apply && !w_oor;
    assign w_flag_oor  = w_is_data && r_mode_apply && w_oor;
    assign w_row       = r_write_pointer[ADDR_W-1:1];
    assign w_addr_even = r_write_pointer[0] ? (w_row + 1'b1) : w_row;

    // Bounding box at the terminator, 8-bit wrap.
    assign w_box_width  = r_max_x_end - r_min_x;
    assign w_box_height = r_max_y - r_min_y + 8'd1;

    // Next stream state.
    always_comb begin
        n_expect_header = r_expect_header;
        n_words_left    = r_words_left;
        n_write_pointer = r_write_pointer;
        n_min_x         = r_min_x;
        n_min_y         = r_min_y;
        n_max_x_end     = r_max_x_end;
        n_max_y         = r_max_y;
        if (w_is_term) begin
            n_min_x     = BOX_MIN_RST;
            n_min_y     = BOX_MIN_RST;
            n_max_x_end = 8'h00;
            n_max_y     = 8'h00;
        end else if (w_is_head) begin
            if (w_x < r_min_x)       n_min_x     = w_x;
            if (w_y < r_min_y)       n_min_y     = w_y;
            if (w_xend > r_max_x_end) n_max_x_end = w_xend;
            if (w_y > r_max_y)       n_max_y     = w_y;
            n_write_pointer = w_head_ptr;
            n_words_left    = {w_runs, 1'b0};
            n_expect_header = 1'b0;
        end else begin
            n_write_pointer = r_write_pointer + 16'd2;
            if (r_words_left != 5'd0) begin
                n_words_left = r_words_left - 5'd1;
            end
            n_expect_header = (n_words_left == 5'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_header <= 1'b1;
            r_words_left    <= 5'd0;
            r_write_pointer <= 16'h0000;
            r_min_x         <= BOX_MIN_RST;
            r_min_y         <= BOX_MIN_RST;
            r_max_x_end     <= 8'h00;
            r_max_y         <= 8'h00;
        end else if (w_accept) begin
            r_expect_header <= n_expect_header;
            r_words_left    <= n_words_left;
            r_write_pointer <= n_write_pointer;
            r_min_x         <= n_min_x;
            r_min_y         <= n_min_y;
            r_max_x_end     <= n_max_x_end;
            r_max_y         <= n_max_y;
        end
    end

    // Store read at accept for a data word that writes.
    always_comb begin
        w_rd.en        = w_accept && w_do_wr;
        w_rd.addr_even = w_addr_even;
        w_rd.addr_odd  = w_row;
    end

    // Read stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_wr         <= w_do_wr;
            r_s1_oor        <= w_flag_oor;
            r_s1_done       <= w_is_term;
            r_s1_odd        <= r_write_pointer[0];
            r_s1_idx        <= w_do_wr ? r_write_pointer[12:0] : 13'd0;
            r_s1_lo         <= w_word[7:0];
            r_s1_hi         <= w_word[15:8];
            r_s1_addr_even  <= w_addr_even;
            r_s1_addr_odd   <= w_row;
            r_s1_box_left   <= w_is_term ? r_min_x : 8'h00;
            r_s1_box_top    <= w_is_term ? r_min_y : 8'h00;
            r_s1_box_width  <= w_is_term ? w_box_width : 8'h00;
            r_s1_box_height <= w_is_term ? w_box_height : 8'h00;
        end
    end

    // XOR the data bytes into the old store bytes.
    assign w_cur_lo = r_s1_odd ? w_q.odd  : w_q.even;
    assign w_cur_hi = r_s1_odd ? w_q.even : w_q.odd;
    assign w_new_lo = r_s1_wr ? (w_cur_lo ^ r_s1_lo) : 8'h00;
    assign w_new_hi = r_s1_wr ? (w_cur_hi ^ r_s1_hi) : 8'h00;

    // Write-back as the item moves into the output register.
    always_comb begin
        w_wr.en        = r_s1_valid && r_s1_wr && w_out_free;
        w_wr.addr_even = r_s1_addr_even;
        w_wr.addr_odd  = r_s1_addr_odd;
        w_wr.data_even = r_s1_odd ? w_new_hi : w_new_lo;
        w_wr.data_odd  = r_s1_odd ? w_new_lo : w_new_hi;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s1_valid) begin
            r_out_wr         <= r_s1_wr;
            r_out_idx        <= r_s1_idx;
            r_out_lo         <= w_new_lo;
            r_out_hi         <= w_new_hi;
            r_out_oor        <= r_s1_oor;
            r_out_done       <= r_s1_done;
            r_out_box_left   <= r_s1_box_left;
            r_out_box_top    <= r_s1_box_top;
            r_out_box_width  <= r_s1_box_width;
            r_out_box_height <= r_s1_box_height;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.write_valid   = r_out_wr;
    assign o_out.store_index   = r_out_idx;
    assign o_out.new_low_byte  = r_out_lo;
    assign o_out.new_high_byte = r_out_hi;
    assign o_out.out_of_range  = r_out_oor;
    assign o_out.cell_done     = r_out_done;
    assign o_out.box_left      = r_out_box_left;
    assign o_out.box_top       = r_out_box_top;
    assign o_out.box_width     = r_out_box_width;
    assign o_out.box_height    = r_out_box_height;

endmodule

// File: rtl/srxd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite run XOR decoder checker
// Port-level assertions on the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module srxd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_write_valid,
    input logic        i_out_of_range,
    input logic        i_cell_done,
    input logic [12:0] i_store_index,
    input logic [7:0]  i_new_low_byte,
    input logic [7:0]  i_new_high_byte
);

    // After reset the store sweep keeps the input closed.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready right after reset");

    // A dropped write never reports written bytes.
    a_wr_oor_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_write_valid && i_out_of_range))
        else $error("write_valid and out_of_range together");

    // The terminator item carries no store write.
    a_done_no_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_cell_done |-> !i_write_valid && !i_out_of_range)
        else $error("terminator item with store activity");

    // Store fields are zero when no bytes were written.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_write_valid |->
            i_store_index == 13'd0 && i_new_low_byte == 8'h00 &&
            i_new_high_byte == 8'h00)
        else $error("store fields set without a write");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

endmodule

bind sprite_run_xor_decoder_unit srxd_checker u_srxd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_write_valid   (o_out.write_valid),
    .i_out_of_range  (o_out.out_of_range),
    .i_cell_done     (o_out.cell_done),
    .i_store_index   (o_out.store_index),
    .i_new_low_byte  (o_out.new_low_byte),
    .i_new_high_byte (o_out.new_high_byte)
);
